### design/bpa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Shared constants, codes and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int MaxPagesDefault    = 4096;
  localparam int MapWordBitsDefault = 32;
  localparam int CountW             = 13;
  localparam int PageW              = 12;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_MARK  = 2'd2;
  localparam logic [1:0] REQ_NOP   = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NO_RUN = 2'd1;
  localparam logic [1:0] ST_ZERO   = 2'd2;
  localparam logic [1:0] ST_RANGE  = 2'd3;

  typedef struct packed {
    logic load;      // capture request, reset run counter, position at scan start
    logic restart;   // move to page 0, clear run counter and rover (retry)
    logic rd;        // read word at current position
    logic step;      // examine one page, advance position
    logic wr;        // write back modified word
    logic fill_set;  // set (1) or clear (0) during fill
    logic fill_step; // modify one page of the run in the held word
    logic ld_fill;   // begin fill from run start
  } bpa_cmd_t;

  typedef struct packed {
    logic found;     // run complete this step
    logic at_lim;    // position reached limit
    logic word_end;  // position leaves the held word after this step
    logic fill_done; // last page of run filled
    logic rover_zero;
  } bpa_sts_t;

endpackage

### design/bpa_datapath.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator datapath
// Bitmap memory, held word, page position, run counter, rover and fill end.
// ----------------------------------------------------------------------------
module bpa_datapath #(
  parameter int MAX_PAGES     = bpa_pkg::MaxPagesDefault,
  parameter int MAP_WORD_BITS = bpa_pkg::MapWordBitsDefault
) (
  input  logic                      clk,
  input  logic                      rst,
  input  bpa_pkg::bpa_cmd_t         cmd,
  input  logic                      clr,
  output bpa_pkg::bpa_sts_t         sts,
  input  logic [1:0]                req_type,
  input  logic [bpa_pkg::PageW-1:0] start_page,
  input  logic [bpa_pkg::CountW-1:0] page_count,
  input  logic [bpa_pkg::CountW-1:0] lim,
  output logic [bpa_pkg::PageW-1:0] run_first
);
  import bpa_pkg::*;

  localparam int Words = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int WW    = (Words > 1) ? $clog2(Words) : 1;
  localparam int BW    = $clog2(MAP_WORD_BITS);
  localparam int PW    = WW + BW;

  logic [MAP_WORD_BITS-1:0] mem [Words];
  logic [MAP_WORD_BITS-1:0] word;
  logic [PW:0]              pos;
  logic [CountW-1:0]        seen;
  logic [CountW-1:0]        count;
  logic [1:0]               req;
  logic [PW-1:0]            rover;
  logic [PW:0]              fend;
  logic [BW-1:0]            bidx;
  logic                     bit_used;
  logic [CountW-1:0]        seen_next;
  logic [PW:0]              scan_from;
  logic [WW-1:0]            waddr;
  logic [WW-1:0]            caddr;

  assign bidx      = pos[BW-1:0];
  assign waddr     = pos[PW-1:BW];
  assign caddr     = WW'(start_page >> BW);
  assign bit_used  = word[bidx];
  assign seen_next = bit_used ? '0 : seen + 1'b1;
  assign scan_from = (req_type == REQ_ALLOC) ? {1'b0, rover} : (PW+1)'(start_page);

  assign sts.found      = !bit_used && (seen_next == count);
  assign sts.at_lim     = (pos >= (PW+1)'(lim)) || (pos >= (PW+1)'(MAX_PAGES));
  assign sts.word_end   = (bidx == BW'(MAP_WORD_BITS - 1));
  assign sts.fill_done  = (pos == fend);
  assign sts.rover_zero = (rover == '0);
  assign run_first      = PageW'(pos);

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      word <= mem[waddr];
    end else if (cmd.fill_step) begin
      word[bidx] <= cmd.fill_set;
    end
    if (clr) begin
      mem[caddr] <= '0;
    end else if (cmd.wr) begin
      mem[waddr] <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rover <= '0;
      pos   <= '0;
      seen  <= '0;
      count <= '0;
      req   <= '0;
      fend  <= '0;
    end else begin
      if (cmd.load) begin
        pos   <= scan_from;
        seen  <= '0;
        count <= page_count;
        req   <= req_type;
        fend  <= (PW+1)'(start_page) + (PW+1)'(page_count) - 1'b1;
      end else if (cmd.restart) begin
        pos   <= '0;
        seen  <= '0;
        rover <= '0;
      end else if (cmd.ld_fill) begin
        fend <= pos;
        pos  <= pos + 1'b1 - (PW+1)'(count);
      end else if (cmd.step) begin
        seen <= seen_next;
        pos  <= pos + 1'b1;
      end else if (cmd.fill_step) begin
        if (req == REQ_ALLOC) begin
          rover <= PW'(fend);
        end else if (req == REQ_MARK && !bit_used) begin
          rover <= PW'(pos);
        end
        if (pos != fend && !sts.word_end) begin
          pos <= pos + 1'b1;
        end
      end else if (cmd.wr) begin
        if (pos != fend) begin
          pos <= pos + 1'b1;
        end
      end
    end
  end

endmodule

### design/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator controller
// Sequences bitmap scan, retry and fill; one page per cycle but for word I/O.
// ----------------------------------------------------------------------------
module bpa_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_fire,
  input  logic [1:0]                 req_type,
  input  logic [bpa_pkg::PageW-1:0]  start_page,
  input  logic [bpa_pkg::CountW-1:0] page_count,
  input  logic [bpa_pkg::CountW-1:0] lim,
  input  logic [bpa_pkg::PageW-1:0]  run_first,
  input  bpa_pkg::bpa_sts_t          sts,
  output bpa_pkg::bpa_cmd_t          cmd,
  output logic                       busy,
  output logic                       res_valid,
  output logic [bpa_pkg::PageW-1:0]  res_first,
  output logic [1:0]                 res_status
);
  import bpa_pkg::*;

  typedef enum logic [3:0] {
    IDLE, SREAD, SCAN, FREAD, FILL, FWRITE, FDONE, DONE
  } state_t;

  state_t      state;
  logic [1:0]  req;
  logic        tried;
  logic [PageW-1:0] first;
  logic [CountW:0]  range_end;

  assign range_end = {1'b0, CountW'(start_page)} + {1'b0, page_count};
  assign busy      = (state != IDLE);

  always_comb begin
    cmd = '0;
    cmd.fill_set = (req != REQ_FREE);
    case (state)
      IDLE:   cmd.load = in_fire;
      SREAD:  cmd.rd = !sts.at_lim;
      SCAN:   cmd.step = !sts.at_lim && !sts.found;
      FREAD:  cmd.rd = 1'b1;
      FILL:   cmd.fill_step = 1'b1;
      FWRITE: cmd.wr = 1'b1;
      default: ;
    endcase
    if (state == SCAN && !sts.at_lim && sts.found) cmd.ld_fill = 1'b1;
    if (state == SREAD && sts.at_lim && !tried && !sts.rover_zero) cmd.restart = 1'b1;
    if (state == SCAN && sts.at_lim && !tried && !sts.rover_zero) cmd.restart = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      res_valid  <= 1'b0;
      req        <= '0;
      tried      <= 1'b0;
      first      <= '0;
      res_first  <= '0;
      res_status <= ST_OK;
    end else begin
      case (state)
        IDLE: begin
          res_valid <= 1'b0;
          if (in_fire) begin
            req   <= req_type;
            tried <= 1'b0;
            res_first <= '0;
            if (req_type == REQ_NOP) begin
              res_status <= ST_OK;
              state      <= DONE;
            end else if (page_count == '0) begin
              res_status <= ST_ZERO;
              state      <= DONE;
            end else if (req_type == REQ_ALLOC) begin
              res_status <= ST_OK;
              state      <= SREAD;
            end else if (range_end > {1'b0, lim}) begin
              res_status <= ST_RANGE;
              state      <= DONE;
            end else begin
              res_status <= ST_OK;
              state      <= FREAD;
            end
          end
        end
        SREAD: begin
          if (sts.at_lim) begin
            if (cmd.restart) begin
              tried <= 1'b1;
            end else begin
              res_status <= ST_NO_RUN;
              state      <= DONE;
            end
          end else begin
            state <= SCAN;
          end
        end
        SCAN: begin
          if (sts.at_lim) begin
            if (cmd.restart) begin
              tried <= 1'b1;
              state <= SREAD;
            end else begin
              res_status <= ST_NO_RUN;
              state      <= DONE;
            end
          end else if (sts.found) begin
            state <= FDONE;
          end else if (sts.word_end) begin
            state <= SREAD;
          end
        end
        FDONE: begin
          first <= run_first;
          state <= FREAD;
        end
        FREAD: state <= FILL;
        FILL: begin
          if (sts.fill_done || sts.word_end) state <= FWRITE;
        end
        FWRITE: begin
          if (sts.fill_done) begin
            if (req == REQ_ALLOC) res_first <= first;
            state <= DONE;
          end else begin
            state <= FREAD;
          end
        end
        DONE: begin
          res_valid <= 1'b1;
          state     <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

### design/bitmap_page_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator
// Next-fit page run allocator over a one-bit-per-page bitmap.
// ----------------------------------------------------------------------------
// Input items on s_axis: allocate, free or mark-used a run of pages. One
// result item per request leaves on m_axis. pages_in_use is written through
// cfg_we/cfg_wdata; the user must write it only while the block is idle,
// as the block itself does not enforce it. One request is in work at a time;
// s_axis_tready is low meanwhile. Allocation scans one page per cycle
// from the rover, one bitmap word read per 32 pages, with one retry from
// page 0 if the rover was not already there, then fills the run one page
// per cycle with a read and write-back per word. Free and mark-used walk
// the run the same way. The result sits in an output register; a stalled
// receiver holds it and holds off the next request until it is taken.
// Reset clears the rover and sets pages_in_use to 4096. The bitmap memory is
// then cleared by a pass of one word per cycle (128 words at the default
// size) during which no request is taken.
// ----------------------------------------------------------------------------
module bitmap_page_allocator #(
  parameter int MAX_PAGES     = bpa_pkg::MaxPagesDefault,
  parameter int MAP_WORD_BITS = bpa_pkg::MapWordBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // req_type[1:0], start_page[13:2], page_count[26:14]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // first_page[11:0], status[13:12]
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata
);
  import bpa_pkg::*;

  localparam int Words = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int WW    = (Words > 1) ? $clog2(Words) : 1;

  logic [CountW-1:0] pages_in_use;
  logic [CountW-1:0] lim;
  logic              busy;
  logic              res_valid;
  logic [PageW-1:0]  res_first;
  logic [1:0]        res_status;
  logic              in_fire;
  logic              clearing;
  logic [WW:0]       clr_idx;
  bpa_cmd_t          cmd;
  bpa_cmd_t          dp_cmd;
  bpa_sts_t          sts;
  logic [PageW-1:0]  run_first;
  logic [PageW-1:0]  dp_start;
  logic [CountW-1:0] dp_count;
  logic [1:0]        dp_req;

  assign lim = (32'(pages_in_use) > 32'(MAX_PAGES)) ? CountW'(MAX_PAGES) : pages_in_use;
  assign s_axis_tready = !busy && !res_valid && !m_axis_tvalid && !clearing;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pages_in_use  <= CountW'(4096);
      m_axis_tvalid <= 1'b0;
      clearing      <= 1'b1;
      clr_idx       <= '0;
    end else begin
      if (cfg_we) pages_in_use <= cfg_wdata;
      if (clearing) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == (WW+1)'(Words - 1)) clearing <= 1'b0;
      end
      if (res_valid) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= {2'b00, res_status, res_first};
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // clearing pass drives the datapath clear port: present the word's start page, write zero
  always_comb begin
    dp_cmd   = cmd;
    dp_req   = s_axis_tdata[1:0];
    dp_start = s_axis_tdata[13:2];
    dp_count = s_axis_tdata[26:14];
    if (clearing) begin
      dp_cmd   = '0;
      dp_cmd.load = 1'b1;
      dp_req   = REQ_FREE;
      dp_start = PageW'(32'(clr_idx[WW-1:0]) * MAP_WORD_BITS);
      dp_count = CountW'(1);
    end
  end

  bpa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_fire    (in_fire),
    .req_type   (s_axis_tdata[1:0]),
    .start_page (s_axis_tdata[13:2]),
    .page_count (s_axis_tdata[26:14]),
    .lim        (lim),
    .run_first  (run_first),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy),
    .res_valid  (res_valid),
    .res_first  (res_first),
    .res_status (res_status)
  );

  bpa_datapath #(
    .MAX_PAGES     (MAX_PAGES),
    .MAP_WORD_BITS (MAP_WORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (dp_cmd),
    .clr        (clearing),
    .sts        (sts),
    .req_type   (dp_req),
    .start_page (dp_start),
    .page_count (dp_count),
    .lim        (lim),
    .run_first  (run_first)
  );

endmodule

### test/bitmap_page_allocator_checker.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator checker
// Watches the request, result and register ports, keeps its own copy of the
// page bitmap, rover and page limit, and compares every result item in order.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata,
  output int          mismatches,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import bpa_pkg::*;

  typedef struct packed {
    logic [PageW-1:0] first_page;
    logic [1:0]       status;
  } alloc_result_t;

  bit [MaxPagesDefault-1:0] used_map;
  int                       rover;
  logic [CountW-1:0]        page_limit;
  alloc_result_t            expected_results[$];

  assign pending = expected_results.size();

  task automatic report(input string what);
    $display("%0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic bit find_free_run(input int from, input int lim, input int count,
                                       output int last);
    int seen;
    seen = 0;
    last = 0;
    for (int p = from; p < lim; p++) begin
      if (!used_map[p]) begin
        seen++;
        if (seen == count) begin
          last = p;
          return 1'b1;
        end
      end else begin
        seen = 0;
      end
    end
    return 1'b0;
  endfunction

  function automatic alloc_result_t serve_request(input logic [1:0] req,
                                                  input int start, input int count);
    alloc_result_t r;
    int lim;
    int last;
    bit found;
    r = '0;
    r.status = ST_OK;
    lim = (page_limit > MaxPagesDefault) ? MaxPagesDefault : int'(page_limit);
    if (req != REQ_ALLOC && req != REQ_FREE && req != REQ_MARK) begin
      r.status = ST_OK;
    end else if (count == 0) begin
      r.status = ST_ZERO;
    end else if (req == REQ_ALLOC) begin
      found = find_free_run(rover, lim, count, last);
      if (!found && rover != 0) begin
        rover = 0;
        found = find_free_run(0, lim, count, last);
      end
      if (found) begin
        r.first_page = PageW'(last + 1 - count);
        for (int p = last + 1 - count; p <= last; p++) used_map[p] = 1'b1;
        rover = last;
      end else begin
        r.status = ST_NO_RUN;
      end
    end else if (start + count > lim) begin
      r.status = ST_RANGE;
    end else if (req == REQ_FREE) begin
      for (int p = start; p < start + count; p++) used_map[p] = 1'b0;
    end else begin
      for (int p = start; p < start + count; p++) begin
        if (!used_map[p]) begin
          used_map[p] = 1'b1;
          rover = p;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_result_t got;
    alloc_result_t want;
    if (rst) begin
      used_map = '0;
      rover = 0;
      page_limit = CountW'(MaxPagesDefault);
      expected_results.delete();
      mismatches = mismatches;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.first_page = m_axis_tdata[11:0];
        got.status     = m_axis_tdata[13:12];
        if (expected_results.size() == 0) begin
          report($sformatf("unexpected result first_page=%0d status=%0d",
                           got.first_page, got.status));
        end else begin
          want = expected_results.pop_front();
          if (got.first_page !== want.first_page)
            report($sformatf("first_page %0d, expected %0d", got.first_page,
                             want.first_page));
          if (got.status !== want.status)
            report($sformatf("status %0d, expected %0d", got.status, want.status));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(serve_request(s_axis_tdata[1:0],
                                                 int'(s_axis_tdata[13:2]),
                                                 int'(s_axis_tdata[26:14])));
      if (cfg_we) page_limit = cfg_wdata;
    end
  end

  initial mismatches = 0;
endmodule

### test/bitmap_page_allocator_test.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator testbench
// Directed and random allocate, free and mark-used requests over several page
// limits, with bursty requests and a stalling result receiver.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bpa_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_we = 1'b0;
  logic [12:0] cfg_wdata = '0;
  int          mismatches;
  int          pending;
  int          items_sent = 0;
  int          burst_left = 0;
  int          lim = MaxPagesDefault;
  bit          hold_off = 1'b0;
  int          stall_mode = 0;
  int          stall_tick = 0;

  always #6 clk = ~clk;

  bitmap_page_allocator dut (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we, .cfg_wdata
  );

  bitmap_page_allocator_checker checker_i (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we, .cfg_wdata,
    .mismatches, .pending
  );

  always @(negedge clk) begin
    stall_tick++;
    if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready = !hold_off;
      1: m_axis_tready = !hold_off && $urandom_range(0, 1);
      2: m_axis_tready = !hold_off && ($urandom_range(0, 7) == 0);
      default: m_axis_tready = !hold_off && stall_tick[0];
    endcase
  end

  initial begin
    wait (items_sent >= 120);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (400) @(negedge clk);
    hold_off = 1'b0;
  end

  task automatic send_request(input logic [1:0] req, input int start, input int count);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    s_axis_tdata = {5'b0, 13'(count), 12'(start), req};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    burst_left--;
    items_sent++;
  endtask

  task automatic set_page_limit(input int value);
    wait (pending == 0);
    repeat (8) @(negedge clk);
    cfg_wdata = 13'(value);
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    lim = (value > MaxPagesDefault) ? MaxPagesDefault : value;
  endtask

  function automatic int short_count(input int cap);
    if (cap < 1) return 1;
    if ($urandom_range(0, 19) == 0) return $urandom_range(1, cap);
    return $urandom_range(1, (cap < 16) ? cap : 16);
  endfunction

  task automatic random_requests(input int n);
    int pick;
    int start;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      start = $urandom_range(0, lim - 1);
      if (pick < 45) begin
        send_request(REQ_ALLOC, $urandom_range(0, 4095), short_count(lim));
      end else if (pick < 78) begin
        send_request(REQ_FREE, start, short_count(lim - start));
      end else if (pick < 90) begin
        send_request(REQ_MARK, start, short_count(lim - start));
      end else if (pick < 94) begin
        send_request(2'($urandom_range(0, 3)), $urandom_range(0, 4095), 0);
      end else if (pick < 98) begin
        send_request(($urandom_range(0, 1)) ? REQ_FREE : REQ_MARK,
                     $urandom_range(0, 4095), $urandom_range(1, 8191));
      end else begin
        send_request(REQ_NONE, $urandom_range(0, 4095), $urandom_range(0, 8191));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_request(REQ_ALLOC, 0, 0);
    send_request(REQ_FREE, 5, 0);
    send_request(REQ_MARK, 4095, 0);
    send_request(REQ_NONE, 4095, 8191);
    send_request(REQ_ALLOC, 4095, 1);
    send_request(REQ_ALLOC, 0, 3);
    send_request(REQ_MARK, 4090, 6);
    send_request(REQ_FREE, 4095, 2);
    send_request(REQ_MARK, 4095, 1);
    send_request(REQ_ALLOC, 0, 4096);
    send_request(REQ_FREE, 0, 4096);
    send_request(REQ_ALLOC, 0, 4096);
    send_request(REQ_ALLOC, 0, 1);
    send_request(REQ_FREE, 0, 4096);
    send_request(REQ_MARK, 10, 5);
    send_request(REQ_MARK, 8, 10);
    send_request(REQ_MARK, 8, 10);
    send_request(REQ_ALLOC, 0, 5);
    send_request(REQ_FREE, 2048, 8191);
    send_request(REQ_FREE, 0, 4096);
    random_requests(50);

    set_page_limit(1);
    send_request(REQ_ALLOC, 0, 1);
    send_request(REQ_ALLOC, 0, 1);
    send_request(REQ_ALLOC, 0, 2);
    random_requests(40);

    set_page_limit(64);
    random_requests(300);
    set_page_limit(256);
    random_requests(250);
    set_page_limit(37);
    random_requests(150);
    set_page_limit(4096);
    random_requests(60);

    wait (pending == 0);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #500ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

### sim.f
design/bpa_pkg.sv
design/bpa_datapath.sv
design/bpa_ctrl.sv
design/bitmap_page_allocator.sv
test/bitmap_page_allocator_checker.sv
test/bitmap_page_allocator_test.sv
